@@ sv/ivm_pkg.sv @@
`default_nettype none

package ivm_pkg;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_NOTIMPL  = 4'd1;
	localparam logic [3:0] ST_POPEMPTY = 4'd2;
	localparam logic [3:0] ST_PUSHFULL = 4'd3;
	localparam logic [3:0] ST_FLAGRACE = 4'd4;
	localparam logic [3:0] ST_MEMOVF   = 4'd5;
	localparam logic [3:0] ST_DISPOVF  = 4'd6;
	localparam logic [3:0] ST_BADKEY   = 4'd7;
	localparam logic [3:0] ST_WAIT     = 4'd8;

	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_STEP  = 3'd1;
	localparam logic [2:0] CMD_READ  = 3'd2;
	localparam logic [2:0] CMD_ROW   = 3'd3;
	localparam logic [2:0] CMD_SETPC = 3'd4;

	localparam int DISP_COLS = 64;
	localparam int DISP_ROWS = 32;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [3:0] OPC_SYS  = 4'h0;
	localparam logic [3:0] OPC_JP   = 4'h1;
	localparam logic [3:0] OPC_CALL = 4'h2;
	localparam logic [3:0] OPC_SE   = 4'h3;
	localparam logic [3:0] OPC_SNE  = 4'h4;
	localparam logic [3:0] OPC_SER  = 4'h5;
	localparam logic [3:0] OPC_LD   = 4'h6;
	localparam logic [3:0] OPC_ADD  = 4'h7;
	localparam logic [3:0] OPC_ALU  = 4'h8;
	localparam logic [3:0] OPC_SNER = 4'h9;
	localparam logic [3:0] OPC_LDI  = 4'hA;
	localparam logic [3:0] OPC_JPV0 = 4'hB;
	localparam logic [3:0] OPC_RND  = 4'hC;
	localparam logic [3:0] OPC_DRW  = 4'hD;
	localparam logic [3:0] OPC_KEY  = 4'hE;
	localparam logic [3:0] OPC_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [7:0] KK_SKP  = 8'h9E;
	localparam logic [7:0] KK_SKNP = 8'hA1;
	localparam logic [7:0] KK_LDDT = 8'h07;
	localparam logic [7:0] KK_WKEY = 8'h0A;
	localparam logic [7:0] KK_SDT  = 8'h15;
	localparam logic [7:0] KK_SST  = 8'h18;
	localparam logic [7:0] KK_ADDI = 8'h1E;
	localparam logic [7:0] KK_FONT = 8'h29;
	localparam logic [7:0] KK_BCD  = 8'h33;
	localparam logic [7:0] KK_STR  = 8'h55;
	localparam logic [7:0] KK_LDR  = 8'h65;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_RDW,
		S_F1,
		S_F2,
		S_VY,
		S_EXEC,
		S_SP_RD,
		S_SP_ROW,
		S_SP_BIT,
		S_BCD,
		S_ST,
		S_LD_RD,
		S_LD_WR,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

@@ sv/interpreted_vm_instruction_step_core.sv @@
// Executes one command per transaction on an 8-bit interpreted virtual machine: memory write,
// memory read, display row read, pc load, or one full instruction step (timers, fetch,
// decode, execute). Program memory is a single-port synchronous RAM, and every command
// funnels its memory traffic through that one port: an instruction step fetches its two
// opcode bytes one after the other, a register block copy makes one write (store) or one
// read (load) per register, BCD makes three writes, and a sprite draw reads one byte per
// sprite row, then steps through that row's pixels one at a time.
// One transaction is worked at a time; a finished result sits in the output register,
// so the next command is taken while it waits. Reading never-written memory is undefined.
`default_nettype none

module interpreted_vm_instruction_step_core #(
	parameter int MEMORY_BYTES = 4096,
	parameter int STACK_DEPTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        font_base_we,
	input  logic [11:0] font_base_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [15:0] keystate,
	input  logic [7:0]  ticks,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [7:0]  read_data,
	output logic [63:0] row_bits,
	output logic [11:0] pc_now,
	output logic        sound_on
);

	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [16:0] MEM_LIM = 17'(MEMORY_BYTES);
	localparam logic [CW-1:0] STK_FULL = CW'(STACK_DEPTH);
	localparam logic [14:0] PIX_LIM = 15'(ivm_pkg::DISP_COLS * ivm_pkg::DISP_ROWS);

	ivm_pkg::state_t state_q, state_d;

	logic [2:0]  cmd_q;
	logic [11:0] addr_q;
	logic [7:0]  wdata_q;
	logic [15:0] keys_q;
	logic [7:0]  ticks_q;
	logic [7:0]  rnd_q;

	logic [11:0]   pc_q;
	logic [15:0]   index_q;
	logic [7:0]    dt_q;
	logic [7:0]    snd_q;
	logic [CW-1:0] sc_q;
	logic [11:0]   font_q;
	logic [7:0]    regs_q  [16];
	logic [63:0]   frame_q [ivm_pkg::DISP_ROWS];
	logic [11:0]   stack_q [STACK_DEPTH];

	logic [7:0]  op_hi_q;
	logic [15:0] op_q;
	logic [7:0]  vx_q;
	logic [7:0]  vy_q;
	logic [3:0]  stp_q;
	logic [7:0]  rdp_q;
	logic [63:0] rowp_q;
	logic [3:0]  cnt_q;
	logic [3:0]  bit_q;
	logic [7:0]  bits_q;
	logic [14:0] pos_q;
	logic [7:0]  bcd_h_q, bcd_t_q, bcd_o_q;
	logic [1:0]  bcd_i_q;

	logic        ovalid_q;
	logic [3:0]  ostat_q;
	logic [7:0]  ord_q;
	logic [63:0] orow_q;
	logic [11:0] opc_q;
	logic        osnd_q;

	logic [7:0] mem [MEMORY_BYTES];
	logic [7:0] mrd_q;
	logic       rok_q;
	logic        me, mwe, minr;
	logic [16:0] maddr;
	logic [7:0]  mwd;
	logic [7:0]  mdata;

	logic        accept, fin_go;
	logic [3:0]  x, y, n;
	logic [7:0]  kk;
	logic [11:0] nnn, pc_next, pc_skip;
	logic        key_hit;
	logic        spr_ovf, bcd_ovf, blk_ovf;
	logic [11:0] base12;
	logic [16:0] blk_addr;
	logic [7:0]  bits_sh;
	logic        bit_more;
	logic [14:0] cur_pos;
	logic        cur_set;
	logic [7:0]  h8, rem8, tens8, ones8;
	logic [15:0] tens_prod;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ivm_pkg::S_IDLE);
	assign fin_go    = (state_q == ivm_pkg::S_FIN) && (!ovalid_q || !out_stall);
	assign out_valid = ovalid_q;
	assign status    = ostat_q;
	assign read_data = ord_q;
	assign row_bits  = orow_q;
	assign pc_now    = opc_q;
	assign sound_on  = osnd_q;

	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign kk  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign pc_next = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign key_hit = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];

	assign spr_ovf  = ({1'b0, index_q} + 17'(n)) > MEM_LIM;
	assign bcd_ovf  = ({1'b0, index_q} + 17'd3) > MEM_LIM;
	assign base12   = index_q[11:0];
	assign blk_ovf  = ({5'd0, base12} + 17'(x) + 17'd1) > MEM_LIM;
	assign blk_addr = {5'd0, base12} + 17'(cnt_q);

	assign bits_sh  = 8'(bits_q << bit_q);
	assign bit_more = (bit_q < 4'd8) && (bits_sh != 8'd0);
	assign cur_pos  = pos_q + 15'(bit_q);
	assign cur_set  = bits_q[3'd7 - bit_q[2:0]];

	assign h8        = (vx_q >= 8'd200) ? 8'd2 : ((vx_q >= 8'd100) ? 8'd1 : 8'd0);
	assign rem8      = vx_q - ((vx_q >= 8'd200) ? 8'd200 : ((vx_q >= 8'd100) ? 8'd100 : 8'd0));
	assign tens_prod = 16'(rem8) * 16'd205;
	assign tens8     = 8'(tens_prod >> 11);
	assign ones8     = rem8 - 8'(tens8 * 8'd10);

	assign minr  = maddr < MEM_LIM;
	assign mdata = rok_q ? mrd_q : 8'd0;

	always_comb begin
		state_d = state_q;
		me      = 1'b0;
		mwe     = 1'b0;
		maddr   = '0;
		mwd     = '0;
		unique case (state_q)
			ivm_pkg::S_IDLE: begin
				if (accept) state_d = ivm_pkg::S_CMD;
			end
			ivm_pkg::S_CMD: begin
				case (cmd_q)
					ivm_pkg::CMD_WRITE: begin
						me      = 1'b1;
						mwe     = 1'b1;
						maddr   = {5'd0, addr_q};
						mwd     = wdata_q;
						state_d = ivm_pkg::S_FIN;
					end
					ivm_pkg::CMD_STEP: begin
						me      = 1'b1;
						maddr   = {5'd0, pc_q};
						state_d = ivm_pkg::S_F1;
					end
					ivm_pkg::CMD_READ: begin
						me      = 1'b1;
						maddr   = {5'd0, addr_q};
						state_d = ivm_pkg::S_RDW;
					end
					default: state_d = ivm_pkg::S_FIN;
				endcase
			end
			ivm_pkg::S_RDW: state_d = ivm_pkg::S_FIN;
			ivm_pkg::S_F1: begin
				me      = 1'b1;
				maddr   = {5'd0, pc_q + 12'd1};
				state_d = ivm_pkg::S_F2;
			end
			ivm_pkg::S_F2: state_d = ivm_pkg::S_VY;
			ivm_pkg::S_VY: state_d = ivm_pkg::S_EXEC;
			ivm_pkg::S_EXEC: begin
				state_d = ivm_pkg::S_FIN;
				if (op_q[15:12] == ivm_pkg::OPC_DRW && !spr_ovf)
					state_d = ivm_pkg::S_SP_RD;
				if (op_q[15:12] == ivm_pkg::OPC_MISC) begin
					if (kk == ivm_pkg::KK_BCD && !bcd_ovf) state_d = ivm_pkg::S_BCD;
					if (kk == ivm_pkg::KK_STR && !blk_ovf) state_d = ivm_pkg::S_ST;
					if (kk == ivm_pkg::KK_LDR && !blk_ovf) state_d = ivm_pkg::S_LD_RD;
				end
			end
			ivm_pkg::S_SP_RD: begin
				if (cnt_q == n) begin
					state_d = ivm_pkg::S_FIN;
				end else begin
					me      = 1'b1;
					maddr   = {1'b0, index_q} + 17'(cnt_q);
					state_d = ivm_pkg::S_SP_ROW;
				end
			end
			ivm_pkg::S_SP_ROW: state_d = ivm_pkg::S_SP_BIT;
			ivm_pkg::S_SP_BIT: begin
				if (bit_more) begin
					if (cur_pos >= PIX_LIM) state_d = ivm_pkg::S_FIN;
				end else begin
					state_d = ivm_pkg::S_SP_RD;
				end
			end
			ivm_pkg::S_BCD: begin
				me    = 1'b1;
				mwe   = 1'b1;
				maddr = {1'b0, index_q} + 17'(bcd_i_q);
				mwd   = (bcd_i_q == 2'd0) ? bcd_h_q : ((bcd_i_q == 2'd1) ? bcd_t_q : bcd_o_q);
				if (bcd_i_q == 2'd2) state_d = ivm_pkg::S_FIN;
			end
			ivm_pkg::S_ST: begin
				me    = 1'b1;
				mwe   = 1'b1;
				maddr = blk_addr;
				mwd   = regs_q[cnt_q];
				if (cnt_q == x) state_d = ivm_pkg::S_FIN;
			end
			ivm_pkg::S_LD_RD: begin
				me      = 1'b1;
				maddr   = blk_addr;
				state_d = ivm_pkg::S_LD_WR;
			end
			ivm_pkg::S_LD_WR: begin
				state_d = (cnt_q == x) ? ivm_pkg::S_FIN : ivm_pkg::S_LD_RD;
			end
			ivm_pkg::S_FIN: begin
				if (fin_go) state_d = ivm_pkg::S_IDLE;
			end
			default: state_d = ivm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ivm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		rok_q <= me && !mwe && minr;
		if (me && minr) begin
			if (mwe) begin
				mem[maddr[AW-1:0]] <= mwd;
			end else begin
				mrd_q <= mem[maddr[AW-1:0]];
			end
		end
		if (state_q == ivm_pkg::S_EXEC && op_q[15:12] == ivm_pkg::OPC_CALL && sc_q < STK_FULL)
			stack_q[sc_q[SW-1:0]] <= pc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 12'd512;
			index_q  <= '0;
			dt_q     <= '0;
			snd_q    <= '0;
			sc_q     <= '0;
			font_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			for (int i = 0; i < ivm_pkg::DISP_ROWS; i++) frame_q[i] <= '0;
		end else begin
			if (font_base_we) font_q <= font_base_wdata;

			if (fin_go) begin
				ovalid_q <= 1'b1;
				ostat_q  <= stp_q;
				ord_q    <= rdp_q;
				orow_q   <= rowp_q;
				opc_q    <= pc_q;
				osnd_q   <= (snd_q != 8'd0);
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				ivm_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						addr_q  <= address;
						wdata_q <= write_data;
						keys_q  <= keystate;
						ticks_q <= ticks;
						rnd_q   <= random_byte;
					end
				end
				ivm_pkg::S_CMD: begin
					stp_q  <= ivm_pkg::ST_OK;
					rdp_q  <= '0;
					rowp_q <= '0;
					case (cmd_q)
						ivm_pkg::CMD_WRITE, ivm_pkg::CMD_READ: ;
						ivm_pkg::CMD_STEP: begin
							dt_q  <= (dt_q < ticks_q) ? 8'd0 : dt_q - ticks_q;
							snd_q <= (snd_q < ticks_q) ? 8'd0 : snd_q - ticks_q;
						end
						ivm_pkg::CMD_ROW: begin
							if (addr_q < 12'(ivm_pkg::DISP_ROWS)) rowp_q <= frame_q[addr_q[4:0]];
						end
						ivm_pkg::CMD_SETPC: pc_q <= addr_q;
						default: stp_q <= ivm_pkg::ST_NOTIMPL;
					endcase
				end
				ivm_pkg::S_RDW: rdp_q <= mdata;
				ivm_pkg::S_F1: op_hi_q <= mdata;
				ivm_pkg::S_F2: begin
					op_q <= {op_hi_q, mdata};
					vx_q <= regs_q[op_hi_q[3:0]];
				end
				ivm_pkg::S_VY: vy_q <= regs_q[y];
				ivm_pkg::S_EXEC: begin
					unique case (op_q[15:12])
						ivm_pkg::OPC_SYS: begin
							if (op_q == ivm_pkg::OP_RET) begin
								if (sc_q == '0) begin
									stp_q <= ivm_pkg::ST_POPEMPTY;
								end else begin
									sc_q <= sc_q - CW'(1);
									pc_q <= stack_q[SW'(sc_q - CW'(1))];
								end
							end else begin
								if (op_q == ivm_pkg::OP_CLS) stp_q <= ivm_pkg::ST_NOTIMPL;
								pc_q <= pc_next;
							end
						end
						ivm_pkg::OPC_JP: pc_q <= nnn;
						ivm_pkg::OPC_CALL: begin
							if (sc_q >= STK_FULL) begin
								stp_q <= ivm_pkg::ST_PUSHFULL;
							end else begin
								sc_q <= sc_q + CW'(1);
								pc_q <= nnn;
							end
						end
						ivm_pkg::OPC_SE:   pc_q <= (vx_q == kk) ? pc_skip : pc_next;
						ivm_pkg::OPC_SNE:  pc_q <= (vx_q != kk) ? pc_skip : pc_next;
						ivm_pkg::OPC_SER:  pc_q <= (vx_q == vy_q) ? pc_skip : pc_next;
						ivm_pkg::OPC_SNER: pc_q <= (vx_q != vy_q) ? pc_skip : pc_next;
						ivm_pkg::OPC_LD: begin
							regs_q[x] <= kk;
							pc_q      <= pc_next;
						end
						ivm_pkg::OPC_ADD: begin
							regs_q[x] <= vx_q + kk;
							pc_q      <= pc_next;
						end
						ivm_pkg::OPC_RND: begin
							regs_q[x] <= rnd_q & kk;
							pc_q      <= pc_next;
						end
						ivm_pkg::OPC_LDI: begin
							index_q <= {4'd0, nnn};
							pc_q    <= pc_next;
						end
						ivm_pkg::OPC_JPV0: pc_q <= nnn + 12'(regs_q[0]);
						ivm_pkg::OPC_ALU: begin
							if (x == 4'hF && (n == ivm_pkg::ALU_ADD || n == ivm_pkg::ALU_SUB ||
								n == ivm_pkg::ALU_SHR || n == ivm_pkg::ALU_SUBN ||
								n == ivm_pkg::ALU_SHL)) begin
								stp_q <= ivm_pkg::ST_FLAGRACE;
							end else begin
								pc_q <= pc_next;
								case (n)
									ivm_pkg::ALU_MOV: regs_q[x] <= vy_q;
									ivm_pkg::ALU_OR:  regs_q[x] <= vx_q | vy_q;
									ivm_pkg::ALU_AND: regs_q[x] <= vx_q & vy_q;
									ivm_pkg::ALU_XOR: regs_q[x] <= vx_q ^ vy_q;
									ivm_pkg::ALU_ADD: begin
										regs_q[x]  <= vx_q + vy_q;
										regs_q[15] <= 8'({1'b0, vx_q} + {1'b0, vy_q} >> 8);
									end
									ivm_pkg::ALU_SUB: begin
										regs_q[x]  <= vx_q - vy_q;
										regs_q[15] <= {7'd0, vx_q >= vy_q};
									end
									ivm_pkg::ALU_SHR: begin
										regs_q[x]  <= vx_q >> 1;
										regs_q[15] <= {7'd0, vx_q[0]};
									end
									ivm_pkg::ALU_SUBN: begin
										regs_q[x]  <= vy_q - vx_q;
										regs_q[15] <= {7'd0, vy_q >= vx_q};
									end
									ivm_pkg::ALU_SHL: begin
										regs_q[x]  <= vx_q << 1;
										regs_q[15] <= {7'd0, vx_q[7]};
									end
									default: stp_q <= ivm_pkg::ST_NOTIMPL;
								endcase
							end
						end
						ivm_pkg::OPC_DRW: begin
							if (spr_ovf) begin
								stp_q <= ivm_pkg::ST_MEMOVF;
							end else begin
								regs_q[15] <= '0;
								cnt_q      <= '0;
							end
						end
						ivm_pkg::OPC_KEY: begin
							pc_q <= pc_next;
							if (kk == ivm_pkg::KK_SKP) begin
								if (key_hit) pc_q <= pc_skip;
							end else if (kk == ivm_pkg::KK_SKNP) begin
								if (!key_hit) pc_q <= pc_skip;
							end else begin
								stp_q <= ivm_pkg::ST_NOTIMPL;
							end
						end
						ivm_pkg::OPC_MISC: begin
							case (kk)
								ivm_pkg::KK_LDDT: begin
									regs_q[x] <= dt_q;
									pc_q      <= pc_next;
								end
								ivm_pkg::KK_WKEY: begin
									if (vx_q[7:4] != 4'd0) stp_q <= ivm_pkg::ST_BADKEY;
									else if (!key_hit) stp_q <= ivm_pkg::ST_WAIT;
									else pc_q <= pc_next;
								end
								ivm_pkg::KK_SDT: begin
									dt_q <= vx_q;
									pc_q <= pc_next;
								end
								ivm_pkg::KK_SST: begin
									snd_q <= vx_q;
									pc_q  <= pc_next;
								end
								ivm_pkg::KK_ADDI: begin
									index_q <= index_q + 16'(vx_q);
									pc_q    <= pc_next;
								end
								ivm_pkg::KK_FONT: begin
									index_q <= 16'(font_q) + 16'(16'(vx_q) * 16'd5);
									pc_q    <= pc_next;
								end
								ivm_pkg::KK_BCD: begin
									if (bcd_ovf) stp_q <= ivm_pkg::ST_MEMOVF;
									bcd_h_q <= h8;
									bcd_t_q <= tens8;
									bcd_o_q <= ones8;
									bcd_i_q <= '0;
								end
								ivm_pkg::KK_STR, ivm_pkg::KK_LDR: begin
									if (blk_ovf) stp_q <= ivm_pkg::ST_MEMOVF;
									cnt_q <= '0;
								end
								default: begin
									stp_q <= ivm_pkg::ST_NOTIMPL;
									pc_q  <= pc_next;
								end
							endcase
						end
						default: ;
					endcase
				end
				ivm_pkg::S_SP_RD: begin
					if (cnt_q == n) pc_q <= pc_next;
				end
				ivm_pkg::S_SP_ROW: begin
					bits_q <= mdata;
					bit_q  <= '0;
					pos_q  <= 15'(vx_q) + ((15'(vy_q) + 15'(cnt_q)) << 6);
				end
				ivm_pkg::S_SP_BIT: begin
					if (bit_more) begin
						if (cur_pos >= PIX_LIM) begin
							stp_q <= ivm_pkg::ST_DISPOVF;
						end else begin
							if (cur_set) begin
								if (frame_q[cur_pos[10:6]][cur_pos[5:0]]) regs_q[15] <= 8'd1;
								frame_q[cur_pos[10:6]][cur_pos[5:0]] <=
									~frame_q[cur_pos[10:6]][cur_pos[5:0]];
							end
							bit_q <= bit_q + 4'd1;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ivm_pkg::S_BCD: begin
					bcd_i_q <= bcd_i_q + 2'd1;
					if (bcd_i_q == 2'd2) pc_q <= pc_next;
				end
				ivm_pkg::S_ST: begin
					if (cnt_q == x) pc_q <= pc_next;
					else cnt_q <= cnt_q + 4'd1;
				end
				ivm_pkg::S_LD_RD: ;
				ivm_pkg::S_LD_WR: begin
					regs_q[cnt_q] <= mdata;
					if (cnt_q == x) pc_q <= pc_next;
					else cnt_q <= cnt_q + 4'd1;
				end
				ivm_pkg::S_FIN: ;
				default: ;
			endcase
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= STK_FULL)
		else $error("stack count beyond depth");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ivm_pkg::S_CMD)
		else $error("accepted transaction not dispatched");

	a_fin_output: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid)
		else $error("finished command produced no result");

	a_idle_pc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ivm_pkg::S_IDLE |=> $stable(pc_q))
		else $error("pc changed while idle");

endmodule

`default_nettype wire
